>>> hw/rtl/sha_pkg.sv
// ---------------------------------------------------------------------------
// sha_pkg
// Shared types, codes and helpers for the segment hole allocator.
// ---------------------------------------------------------------------------
package sha_pkg;

  localparam int MAX_HOLES  = 16;
  localparam int ADDR_BITS  = 16;
  localparam int LEN_W      = ADDR_BITS + 1;
  localparam int IDX_W      = $clog2(MAX_HOLES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int MEM_SIZE_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_TOTAL = 2'd1,
    ST_COMPACT  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIT_POLICY  = 2'd0,
    REG_MEMORY_SIZE = 2'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    SH_NONE  = 2'd0,
    SH_LEFT  = 2'd1,   // cells at and above sh_idx take their right neighbor
    SH_RIGHT = 2'd2    // cells above sh_idx take their left neighbor
  } shift_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] request_size;
    logic [15:0] free_base;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] alloc_base;
  } result_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0]     len;
  } hole_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    hole_t            wr_hole;
    shift_e           shift;
    logic [IDX_W-1:0] sh_idx;
  } cell_ctl_t;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
  endfunction

endpackage

>>> hw/rtl/segment_hole_allocator.sv
// ---------------------------------------------------------------------------
// segment_hole_allocator
// Base-sorted free hole table with first/best/worst fit and coalescing free.
// ---------------------------------------------------------------------------
//  channel  | signals                               | accepted when
//  ---------+---------------------------------------+----------------------
//  request  | start, busy, request                  | start & !busy
//  result   | done, result                          | done (one cycle)
//  config   | cfg_valid, cfg_ready, cfg_index/data  | cfg_valid & cfg_ready
//
// Allocate scans every hole; free scans up to the insert position p and then
// checks for neighbors to join; init and unused ops do no scan. The scan reads
// one table slot per cycle. Reset empties the table and clears the total.
// Results cannot be stalled; busy drops in the cycle done is shown.
module segment_hole_allocator import sha_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  request_t              request,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CHECK, S_APPLY} state_t;

  state_t                state;
  request_t              req;
  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      hole_count;
  logic [LEN_W-1:0]      total_free;
  logic [1:0]            fit_policy;
  logic [MEM_SIZE_W-1:0] memory_size;
  logic                  pick_v;
  logic [IDX_W-1:0]      pick_idx;
  hole_t                 pick;
  logic                  prv_v;
  hole_t                 prv;
  logic                  nxt_v;
  hole_t                 nxt;
  logic                  jp;
  logic                  jn;

  hole_t                 holes [MAX_HOLES];
  cell_ctl_t             ctl;
  hole_t                 cur;
  logic [LEN_W-1:0]      sz;
  logic                  fits;
  logic                  take;
  logic                  in_range;
  logic [CNT_W-1:0]      count_next;
  logic [LEN_W-1:0]      total_next;
  logic [1:0]            status_next;
  logic [15:0]           base_next;
  logic [LEN_W-1:0]      shrunk;
  logic [LEN_W-1:0]      merged;
  logic [IDX_W-1:0]      p_idx;
  logic [LEN_W-1:0]      init_len;
  logic [ADDR_BITS+1:0]  prv_end;
  logic [LEN_W:0]        rgn_end;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  // cell chain
  for (genvar g = 0; g < MAX_HOLES; g++) begin : g_cell
    sha_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(g)),
      .ctl      (ctl),
      .left_in  (holes[(g == 0) ? 0 : g - 1]),
      .right_in (holes[(g == MAX_HOLES - 1) ? g : g + 1]),
      .q        (holes[g])
    );
  end

  assign cur      = holes[idx[IDX_W-1:0]];
  assign sz       = LEN_W'(req.request_size);
  assign fits     = cur.len >= sz;
  assign in_range = idx < hole_count;
  assign p_idx    = idx[IDX_W-1:0];
  assign shrunk   = pick.len - sz;
  assign merged   = sat_add(sat_add(prv.len, sz), jn ? nxt.len : '0);
  assign prv_end  = (ADDR_BITS+2)'(prv.start) + (ADDR_BITS+2)'(prv.len);
  assign rgn_end  = (LEN_W+1)'(req.free_base) + (LEN_W+1)'(req.request_size);
  assign init_len = (memory_size > MEM_SIZE_W'(1 << ADDR_BITS))
                    ? LEN_W'(1 << ADDR_BITS) : LEN_W'(memory_size);

  always_comb begin
    unique case (fit_policy)
      FIT_BEST:  take = fits && (!pick_v || cur.len < pick.len);
      FIT_WORST: take = !pick_v || cur.len > pick.len;
      default:   take = fits && !pick_v;
    endcase
  end

  // table update, issued in the apply cycle
  always_comb begin
    ctl         = '0;
    ctl.shift   = SH_NONE;
    count_next  = hole_count;
    total_next  = total_free;
    status_next = ST_OK;
    base_next   = '0;
    if (state == S_APPLY) begin
      case (req.operation)
        OP_ALLOC: begin
          if (total_free < sz) begin
            status_next = ST_NO_TOTAL;
          end else if (!pick_v || pick.len < sz) begin
            status_next = ST_COMPACT;
          end else begin
            base_next  = pick.start;
            total_next = total_free - sz;
            if (shrunk == '0) begin
              ctl.shift  = SH_LEFT;
              ctl.sh_idx = pick_idx;
              count_next = hole_count - 1'b1;
            end else begin
              ctl.wr_en         = 1'b1;
              ctl.wr_idx        = pick_idx;
              ctl.wr_hole.start = pick.start + req.request_size;
              ctl.wr_hole.len   = shrunk;
            end
          end
        end
        OP_FREE: begin
          if (req.request_size == '0) begin
            status_next = ST_OK;
          end else if (!jp && !jn && hole_count >= CNT_W'(MAX_HOLES)) begin
            status_next = ST_FULL;
          end else begin
            total_next = sat_add(total_free, sz);
            ctl.wr_en  = 1'b1;
            if (jp) begin
              ctl.wr_idx      = p_idx - 1'b1;
              ctl.wr_hole     = prv;
              ctl.wr_hole.len = merged;
              if (jn) begin
                ctl.shift  = SH_LEFT;
                ctl.sh_idx = p_idx;
                count_next = hole_count - 1'b1;
              end
            end else if (jn) begin
              ctl.wr_idx        = p_idx;
              ctl.wr_hole.start = req.free_base;
              ctl.wr_hole.len   = sat_add(nxt.len, sz);
            end else begin
              ctl.wr_idx        = p_idx;
              ctl.wr_hole.start = req.free_base;
              ctl.wr_hole.len   = sz;
              ctl.shift         = SH_RIGHT;
              ctl.sh_idx        = p_idx;
              count_next        = hole_count + 1'b1;
            end
          end
        end
        OP_INIT: begin
          total_next = init_len;
          count_next = (init_len != '0) ? CNT_W'(1) : '0;
          ctl.wr_en  = 1'b1;
          ctl.wr_idx = '0;
          ctl.wr_hole.start = '0;
          ctl.wr_hole.len   = init_len;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      hole_count  <= '0;
      total_free  <= '0;
      fit_policy  <= FIT_FIRST;
      memory_size <= MEM_SIZE_W'(4096);
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIT_POLICY:  fit_policy  <= cfg_data[1:0];
          REG_MEMORY_SIZE: memory_size <= cfg_data[MEM_SIZE_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req    <= request;
            idx    <= '0;
            pick_v <= 1'b0;
            prv_v  <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (req.operation == OP_ALLOC) begin
            if (in_range) begin
              if (take) begin
                pick_v   <= 1'b1;
                pick_idx <= idx[IDX_W-1:0];
                pick     <= cur;
              end
              idx <= idx + 1'b1;
            end else begin
              state <= S_APPLY;
            end
          end else if (req.operation == OP_FREE) begin
            if (in_range && cur.start <= req.free_base) begin
              prv_v <= 1'b1;
              prv   <= cur;
              idx   <= idx + 1'b1;
            end else begin
              nxt_v <= in_range;
              nxt   <= cur;
              state <= S_CHECK;
            end
          end else begin
            state <= S_APPLY;
          end
        end
        S_CHECK: begin
          jp    <= prv_v && prv_end == (ADDR_BITS+2)'(req.free_base);
          jn    <= nxt_v && rgn_end == (LEN_W+1)'(nxt.start);
          state <= S_APPLY;
        end
        S_APPLY: begin
          hole_count        <= count_next;
          total_free        <= total_next;
          result.status     <= status_next;
          result.alloc_base <= base_next;
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/sha_cell.sv
// ---------------------------------------------------------------------------
// sha_cell
// One slot of the hole table; loads new data or a neighbor's entry.
// ---------------------------------------------------------------------------
module sha_cell import sha_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctl_t        ctl,
  input  hole_t            left_in,
  input  hole_t            right_in,
  output hole_t            q
);

  hole_t q_next;

  always_comb begin
    q_next = q;
    if (ctl.wr_en && ctl.wr_idx == cell_idx) begin
      q_next = ctl.wr_hole;
    end else if (ctl.shift == SH_LEFT && cell_idx >= ctl.sh_idx) begin
      q_next = right_in;
    end else if (ctl.shift == SH_RIGHT && cell_idx > ctl.sh_idx) begin
      q_next = left_in;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> hw/rtl/sha_checker.sv
// ---------------------------------------------------------------------------
// sha_checker
// Port-level checks for the segment hole allocator.
// ---------------------------------------------------------------------------
module sha_checker import sha_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input result_t  result
);

  // an accepted beat always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted beat did not raise busy");

  // result appears as the block goes idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy)) else $error("done outside end of work");

  // a failed beat grants no address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.alloc_base == '0)
    else $error("nonzero base on failure");

  // done is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held for two cycles");

endmodule

bind segment_hole_allocator sha_checker u_sha_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
